### hdl/skvt_pkg.sv
`default_nettype none

package skvt_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned READ_W      = 32;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned M_TDATA_W   = ((READ_W + COUNT_OUT_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic load;
    logic srch_rd;
    logic srch_cmp;
    logic probe_rd;
    logic probe_cmp;
    logic shift_init_up;
    logic shift_init_dn;
    logic shift_rd;
    logic shift_wr;
    logic write_entry;
    logic count_inc;
    logic count_dec;
    logic clear;
    logic set_miss;
    logic set_full;
    logic set_read;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic            srch_more;
    logic            hit;
    logic            hit_q;
    logic            full;
    logic            shift_more;
    logic            out_free;
    logic [OP_W-1:0] req_type;
  } stat_t;

endpackage

`default_nettype wire

### hdl/sorted_key_value_table.sv
// Sorted key/value table holding up to CAPACITY pairs in ascending key order, one entry per
// key. Each request transfer names an operation in s_axis_tuser (insert or replace, update,
// remove, lookup, clear) and carries a key and a value; exactly one result transfer follows
// with a status in m_axis_tuser, the looked-up value (all ones unless a lookup hits) and the
// entry count after the request. One request is worked on at a time. The time a request takes
// is set by the binary search over the n entries held and by the shift of the m entries moved
// by an insert of a new key or by a remove, both running through the single read port of the
// key and value memories, and it grows while a held-off result keeps the output register busy.
// The memories need no clearing pass after reset, so a request is taken straight after reset.
`default_nettype none

module sorted_key_value_table
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned S_TDATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // key, value
  input  logic [OP_W-1:0]      s_axis_tuser_i,  // req_type
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // read_value, entry_count
  output logic [ST_W-1:0]      m_axis_tuser_o   // status
);

  cmd_t                   cmd;
  stat_t                  stat;
  logic [READ_W-1:0]      read_value;
  logic [COUNT_OUT_W-1:0] entry_count;

  skvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  skvt_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .req_type_i    (s_axis_tuser_i),
    .key_i         (s_axis_tdata_i[KEY_BITS-1:0]),
    .value_i       (s_axis_tdata_i[KEY_BITS +: VALUE_BITS]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .status_o      (m_axis_tuser_o),
    .read_value_o  (read_value),
    .entry_count_o (entry_count)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W - READ_W - COUNT_OUT_W){1'b0}}, entry_count, read_value};

endmodule

`default_nettype wire

### hdl/skvt_ctrl.sv
`default_nettype none

module skvt_ctrl
  import skvt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SRCH  = 9'b000000010,
    S_SCMP  = 9'b000000100,
    S_PROBE = 9'b000001000,
    S_PCMP  = 9'b000010000,
    S_SHIFT = 9'b000100000,
    S_SHWR  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SRCH;
        end
      end
      S_SRCH: begin
        if (stat_i.srch_more) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_SCMP;
        end else begin
          state_d = S_PROBE;
        end
      end
      S_SCMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = S_SRCH;
      end
      S_PROBE: begin
        cmd_o.probe_rd = 1'b1;
        state_d        = S_PCMP;
      end
      S_PCMP: begin
        cmd_o.probe_cmp = 1'b1;
        state_d         = S_RESP;
        case (stat_i.req_type)
          OP_INSERT: begin
            if (stat_i.hit) begin
              state_d = S_WRITE;
            end else if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
            end else begin
              cmd_o.shift_init_up = 1'b1;
              state_d             = S_SHIFT;
            end
          end
          OP_UPDATE: begin
            if (stat_i.hit) begin
              state_d = S_WRITE;
            end else begin
              cmd_o.set_miss = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (stat_i.hit) begin
              cmd_o.shift_init_dn = 1'b1;
              state_d             = S_SHIFT;
            end else begin
              cmd_o.set_miss = 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (stat_i.hit) begin
              cmd_o.set_read = 1'b1;
            end else begin
              cmd_o.set_miss = 1'b1;
            end
          end
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_SHIFT: begin
        if (stat_i.shift_more) begin
          cmd_o.shift_rd = 1'b1;
          state_d        = S_SHWR;
        end else if (stat_i.req_type == OP_REMOVE) begin
          cmd_o.count_dec = 1'b1;
          state_d         = S_RESP;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT;
      end
      S_WRITE: begin
        cmd_o.write_entry = 1'b1;
        cmd_o.count_inc   = (stat_i.req_type == OP_INSERT) && !stat_i.hit_q;
        state_d           = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/skvt_datapath.sv
`default_nettype none

module skvt_datapath
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output stat_t                  stat_o,
  input  logic [OP_W-1:0]        req_type_i,
  input  logic [KEY_BITS-1:0]    key_i,
  input  logic [VALUE_BITS-1:0]  value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ST_W-1:0]        status_o,
  output logic [READ_W-1:0]      read_value_o,
  output logic [COUNT_OUT_W-1:0] entry_count_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [KEY_BITS-1:0]   keys_mem [CAPACITY];
  logic [VALUE_BITS-1:0] vals_mem [CAPACITY];

  logic [OP_W-1:0]       req_type_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [CW-1:0]         lo_q, hi_q, mid_q, ptr_q, count_q;
  logic                  hit_q;
  logic [KEY_BITS-1:0]   rkey_q;
  logic [VALUE_BITS-1:0] rval_q;
  logic [ST_W-1:0]       status_q;
  logic [READ_W-1:0]     rdval_q;
  logic                  out_valid_q;
  logic [ST_W-1:0]       out_status_q;
  logic [READ_W-1:0]     out_read_q;
  logic [COUNT_OUT_W-1:0] out_count_q;

  logic [CW:0]           sum;
  logic [CW-1:0]         mid, src;
  logic                  is_remove, hit, rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [KEY_BITS-1:0]   wr_key;
  logic [VALUE_BITS-1:0] wr_val;
  logic [READ_W-1:0]     hit_val;
  logic [COUNT_OUT_W-1:0] count_ext;

  assign sum       = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid       = sum[CW:1];
  assign is_remove = (req_type_q == OP_REMOVE);
  assign src       = is_remove ? ptr_q + CW'(1) : ptr_q - CW'(1);
  assign hit       = (lo_q < count_q) && (rkey_q == key_q);

  always_comb begin
    rd_addr = lo_q[AW-1:0];
    if (cmd_i.srch_rd) begin
      rd_addr = mid[AW-1:0];
    end else if (cmd_i.shift_rd) begin
      rd_addr = src[AW-1:0];
    end
  end

  assign rd_en   = cmd_i.srch_rd | cmd_i.probe_rd | cmd_i.shift_rd;
  assign wr_en   = cmd_i.shift_wr | cmd_i.write_entry;
  assign wr_addr = cmd_i.shift_wr ? ptr_q[AW-1:0] : lo_q[AW-1:0];
  assign wr_key  = cmd_i.shift_wr ? rkey_q : key_q;
  assign wr_val  = cmd_i.shift_wr ? rval_q : value_q;

  // key and value memories, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      keys_mem[wr_addr] <= wr_key;
      vals_mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rkey_q <= keys_mem[rd_addr];
      rval_q <= vals_mem[rd_addr];
    end
  end

  if (VALUE_BITS >= READ_W) begin : g_rd_trunc
    assign hit_val = rval_q[READ_W-1:0];
  end else begin : g_rd_ext
    assign hit_val = {{(READ_W - VALUE_BITS){1'b0}}, rval_q};
  end

  if (CW >= COUNT_OUT_W) begin : g_cnt_trunc
    assign count_ext = count_q[COUNT_OUT_W-1:0];
  end else begin : g_cnt_ext
    assign count_ext = {{(COUNT_OUT_W - CW){1'b0}}, count_q};
  end

  // request payload and search registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_type_i;
      key_q      <= key_i;
      value_q    <= value_i;
      lo_q       <= '0;
      hi_q       <= count_q;
      status_q   <= ST_OK;
      rdval_q    <= '1;
    end
    if (cmd_i.srch_rd) begin
      mid_q <= mid;
    end
    if (cmd_i.srch_cmp) begin
      if (rkey_q < key_q) begin
        lo_q <= mid_q + CW'(1);
      end else begin
        hi_q <= mid_q;
      end
    end
    if (cmd_i.probe_cmp) begin
      hit_q <= hit;
    end
    if (cmd_i.shift_init_up) begin
      ptr_q <= count_q;
    end else if (cmd_i.shift_init_dn) begin
      ptr_q <= lo_q;
    end else if (cmd_i.shift_wr) begin
      ptr_q <= is_remove ? ptr_q + CW'(1) : ptr_q - CW'(1);
    end
    if (cmd_i.set_miss) begin
      status_q <= ST_MISS;
    end else if (cmd_i.set_full) begin
      status_q <= ST_FULL;
    end
    if (cmd_i.set_read) begin
      rdval_q <= hit_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.clear) begin
      count_q <= '0;
    end else if (cmd_i.count_inc) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.count_dec) begin
      count_q <= count_q - CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.respond) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      out_status_q <= status_q;
      out_read_q   <= rdval_q;
      out_count_q  <= count_ext;
    end
  end

  assign stat_o.srch_more  = (lo_q < hi_q);
  assign stat_o.hit        = hit;
  assign stat_o.hit_q      = hit_q;
  assign stat_o.full       = (count_q == CW'(CAPACITY));
  assign stat_o.shift_more = is_remove ? ((ptr_q + CW'(1)) < count_q) : (ptr_q > lo_q);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.req_type   = req_type_q;

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign read_value_o  = out_read_q;
  assign entry_count_o = out_count_q;

endmodule

`default_nettype wire

### hdl/skvt_checker.sv
`default_nettype none

module skvt_checker
  import skvt_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32,
  localparam int unsigned S_TDATA_W = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input logic [OP_W-1:0]      s_axis_tuser_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [ST_W-1:0]      m_axis_tuser_o
);

  logic [READ_W-1:0]      rd_field;
  logic [COUNT_OUT_W-1:0] cnt_field;

  assign rd_field  = m_axis_tdata_o[READ_W-1:0];
  assign cnt_field = m_axis_tdata_o[READ_W +: COUNT_OUT_W];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // one request in flight
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is at work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_OK || m_axis_tuser_o == ST_MISS
      || m_axis_tuser_o == ST_FULL))
    else $error("unknown status code");

  a_fail_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != ST_OK |-> rd_field == '1)
    else $error("miss or refusal with a read value");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ST_FULL |-> cnt_field == COUNT_OUT_W'(CAPACITY))
    else $error("insert refused below capacity");

endmodule

bind sorted_key_value_table skvt_checker #(
  .CAPACITY   (CAPACITY),
  .KEY_BITS   (KEY_BITS),
  .VALUE_BITS (VALUE_BITS)
) u_skvt_checker (.*);

`default_nettype wire
